### sv/m6502_pd_pkg.sv
`default_nettype none
package m6502_pd_pkg;

    // Addressing modes, in the order of the decode tables.
    typedef enum logic [4:0] {
        AM_XX, AM_IP, AM_RE, AM_RL, AM_IM, AM_I2, AM_ZP, AM_ZX, AM_ZY, AM_AB,
        AM_AX, AM_AY, AM_IA, AM_IL, AM_IX, AM_IY, AM_IZ, AM_IT, AM_BB, AM_LG,
        AM_LX, AM_SR, AM_SY, AM_XD, AM_XY, AM_MV
    } mode_t;

    typedef enum logic [6:0] {
        OP_BAD, OP_ADC, OP_ANC, OP_AND, OP_ASL, OP_ASR, OP_BCC, OP_BCS, OP_BEQ, OP_BIT,
        OP_BMI, OP_BNE, OP_BPL, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_CMP,
        OP_CPX, OP_CPY, OP_DCP, OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_HLE, OP_INC, OP_INX,
        OP_INY, OP_ISB, OP_JMP, OP_JSR, OP_LAX, OP_LDA, OP_LDX, OP_LDY, OP_LSR, OP_NOP,
        OP_ORA, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_RLA, OP_ROL, OP_ROR, OP_RTI, OP_RTS,
        OP_SAX, OP_SBC, OP_SEC, OP_SED, OP_SEI, OP_SLO, OP_SRE, OP_STA, OP_STX, OP_STY,
        OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA,
        OP_BRA, OP_TSB, OP_RMB, OP_BBR, OP_TRB, OP_STZ, OP_SMB, OP_BBS, OP_WAI, OP_STP,
        OP_PLX, OP_PLY, OP_PHX, OP_PHY,
        OP_BRL, OP_COP, OP_JML, OP_JSL, OP_MVN, OP_MVP, OP_PEA, OP_PEI, OP_PHB, OP_PHD,
        OP_PHK, OP_PLB, OP_PLD, OP_REP, OP_RTL, OP_SEP, OP_TCD, OP_TCS, OP_TDC, OP_TSC,
        OP_TXY, OP_TYX, OP_XBA, OP_XCE
    } op_t;

    typedef enum logic [1:0] {
        CPU_NMOS = 2'd0,
        CPU_CMOS = 2'd1,
        CPU_816  = 2'd2
    } cpu_t;

    localparam logic [1:0] CLS_NONE   = 2'd0;
    localparam logic [1:0] CLS_DIRECT = 2'd1;
    localparam logic [1:0] CLS_PTR    = 2'd2;
    localparam logic [1:0] CLS_BRANCH = 2'd3;

    localparam logic [1:0] WID_BYTE = 2'd0;
    localparam logic [1:0] WID_WORD = 2'd1;
    localparam logic [1:0] WID_LONG = 2'd2;

    typedef struct packed {
        mode_t mode;
        op_t   op;
    } dec_t;

    // Decoded beat after the table lookup.
    typedef struct packed {
        mode_t       mode;
        op_t         op;
        logic [15:0] pc;
        logic [7:0]  lo;
        logic [7:0]  mid;
        logic [7:0]  hi;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] s;
    } look_t;

    // Beat carrying every candidate address sum.
    typedef struct packed {
        mode_t       mode;
        op_t         op;
        logic [2:0]  len;
        logic [15:0] next_pc;
        logic [23:0] w24;
        logic [15:0] rel_tgt;
        logic [15:0] rel16_tgt;
        logic [15:0] bb_tgt;
        logic [7:0]  zx;
        logic [7:0]  zy;
        logic [23:0] ax;
        logic [23:0] ay;
        logic [23:0] lx;
        logic [23:0] sr;
    } sums_t;

    function automatic logic [2:0] mode_len(input mode_t m);
        logic [2:0] l;
        unique case (m)
            AM_XX, AM_IP: l = 3'd1;
            AM_RE, AM_IM, AM_ZP, AM_ZX, AM_ZY, AM_IX, AM_IY, AM_IZ, AM_SR, AM_SY,
            AM_XD, AM_XY: l = 3'd2;
            AM_LG, AM_LX: l = 3'd4;
            default: l = 3'd3;
        endcase
        return l;
    endfunction

    localparam dec_t TAB_NMOS [256] = '{
'{AM_XX,OP_BAD},'{AM_IX,OP_ORA},'{AM_XX,OP_BAD},'{AM_IX,OP_SLO},'{AM_ZP,OP_NOP},'{AM_ZP,OP_ORA},
'{AM_ZP,OP_ASL},'{AM_ZP,OP_SLO},'{AM_IP,OP_PHP},'{AM_IM,OP_ORA},'{AM_IP,OP_ASL},'{AM_IM,OP_ANC},
'{AM_AB,OP_NOP},'{AM_AB,OP_ORA},'{AM_AB,OP_ASL},'{AM_AB,OP_SLO},
'{AM_RE,OP_BPL},'{AM_IY,OP_ORA},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZX,OP_NOP},'{AM_ZX,OP_ORA},
'{AM_ZX,OP_ASL},'{AM_ZX,OP_SLO},'{AM_IP,OP_CLC},'{AM_AY,OP_ORA},'{AM_IP,OP_NOP},'{AM_XX,OP_BAD},
'{AM_AX,OP_NOP},'{AM_AX,OP_ORA},'{AM_AX,OP_ASL},'{AM_AX,OP_SLO},
'{AM_AB,OP_JSR},'{AM_IX,OP_AND},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZP,OP_BIT},'{AM_ZP,OP_AND},
'{AM_ZP,OP_ROL},'{AM_XX,OP_BAD},'{AM_IP,OP_PLP},'{AM_IM,OP_AND},'{AM_IP,OP_ROL},'{AM_IM,OP_ANC},
'{AM_AB,OP_BIT},'{AM_AB,OP_AND},'{AM_AB,OP_ROL},'{AM_XX,OP_BAD},
'{AM_RE,OP_BMI},'{AM_IY,OP_AND},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZX,OP_AND},
'{AM_ZX,OP_ROL},'{AM_ZX,OP_RLA},'{AM_IP,OP_SEC},'{AM_AY,OP_AND},'{AM_IP,OP_NOP},'{AM_XX,OP_BAD},
'{AM_AX,OP_NOP},'{AM_AX,OP_AND},'{AM_AX,OP_ROL},'{AM_XX,OP_BAD},
'{AM_IP,OP_RTI},'{AM_IX,OP_EOR},'{AM_I2,OP_HLE},'{AM_IX,OP_SRE},'{AM_ZP,OP_NOP},'{AM_ZP,OP_EOR},
'{AM_ZP,OP_LSR},'{AM_ZP,OP_SRE},'{AM_IP,OP_PHA},'{AM_IM,OP_EOR},'{AM_IP,OP_LSR},'{AM_IM,OP_ASR},
'{AM_AB,OP_JMP},'{AM_AB,OP_EOR},'{AM_AB,OP_LSR},'{AM_AB,OP_SRE},
'{AM_RE,OP_BVC},'{AM_IY,OP_EOR},'{AM_XX,OP_BAD},'{AM_IY,OP_SRE},'{AM_ZX,OP_NOP},'{AM_ZX,OP_EOR},
'{AM_ZX,OP_LSR},'{AM_ZX,OP_SRE},'{AM_IP,OP_CLI},'{AM_AY,OP_EOR},'{AM_IP,OP_NOP},'{AM_AY,OP_SRE},
'{AM_AX,OP_NOP},'{AM_AX,OP_EOR},'{AM_AX,OP_LSR},'{AM_AX,OP_SRE},
'{AM_IP,OP_RTS},'{AM_IX,OP_ADC},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZP,OP_ADC},
'{AM_ZP,OP_ROR},'{AM_XX,OP_BAD},'{AM_IP,OP_PLA},'{AM_IM,OP_ADC},'{AM_IP,OP_ROR},'{AM_XX,OP_BAD},
'{AM_IA,OP_JMP},'{AM_AB,OP_ADC},'{AM_AB,OP_ROR},'{AM_XX,OP_BAD},
'{AM_RE,OP_BVS},'{AM_IY,OP_ADC},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZX,OP_ADC},
'{AM_ZX,OP_ROR},'{AM_XX,OP_BAD},'{AM_IP,OP_SEI},'{AM_AY,OP_ADC},'{AM_IP,OP_NOP},'{AM_XX,OP_BAD},
'{AM_AX,OP_NOP},'{AM_AX,OP_ADC},'{AM_AX,OP_ROR},'{AM_XX,OP_BAD},
'{AM_IM,OP_NOP},'{AM_IX,OP_STA},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZP,OP_STY},'{AM_ZP,OP_STA},
'{AM_ZP,OP_STX},'{AM_XX,OP_BAD},'{AM_IP,OP_DEY},'{AM_IM,OP_STA},'{AM_IP,OP_TXA},'{AM_XX,OP_BAD},
'{AM_AB,OP_STY},'{AM_AB,OP_STA},'{AM_AB,OP_STX},'{AM_AB,OP_SAX},
'{AM_RE,OP_BCC},'{AM_IY,OP_STA},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZX,OP_STY},'{AM_ZX,OP_STA},
'{AM_ZY,OP_STX},'{AM_XX,OP_BAD},'{AM_IP,OP_TYA},'{AM_AY,OP_STA},'{AM_IP,OP_TXS},'{AM_XX,OP_BAD},
'{AM_XX,OP_BAD},'{AM_AX,OP_STA},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},
'{AM_IM,OP_LDY},'{AM_IX,OP_LDA},'{AM_IM,OP_LDX},'{AM_XX,OP_BAD},'{AM_ZP,OP_LDY},'{AM_ZP,OP_LDA},
'{AM_ZP,OP_LDX},'{AM_XX,OP_BAD},'{AM_IP,OP_TAY},'{AM_IM,OP_LDA},'{AM_IP,OP_TAX},'{AM_XX,OP_BAD},
'{AM_AB,OP_LDY},'{AM_AB,OP_LDA},'{AM_AB,OP_LDX},'{AM_AB,OP_LAX},
'{AM_RE,OP_BCS},'{AM_IY,OP_LDA},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZX,OP_LDY},'{AM_ZX,OP_LDA},
'{AM_ZY,OP_LDX},'{AM_XX,OP_BAD},'{AM_IP,OP_CLV},'{AM_AY,OP_LDA},'{AM_IP,OP_TSX},'{AM_XX,OP_BAD},
'{AM_AX,OP_LDY},'{AM_AX,OP_LDA},'{AM_AY,OP_LDX},'{AM_AX,OP_LAX},
'{AM_IM,OP_CPY},'{AM_IX,OP_CMP},'{AM_XX,OP_BAD},'{AM_IX,OP_DCP},'{AM_ZP,OP_CPY},'{AM_ZP,OP_CMP},
'{AM_ZP,OP_DEC},'{AM_ZP,OP_DCP},'{AM_IP,OP_INY},'{AM_IM,OP_CMP},'{AM_IP,OP_DEX},'{AM_XX,OP_BAD},
'{AM_AB,OP_CPY},'{AM_AB,OP_CMP},'{AM_AB,OP_DEC},'{AM_AB,OP_DCP},
'{AM_RE,OP_BNE},'{AM_IY,OP_CMP},'{AM_XX,OP_BAD},'{AM_IY,OP_DCP},'{AM_XX,OP_BAD},'{AM_ZX,OP_CMP},
'{AM_ZX,OP_DEC},'{AM_ZX,OP_DCP},'{AM_IP,OP_CLD},'{AM_AY,OP_CMP},'{AM_IP,OP_NOP},'{AM_AY,OP_DCP},
'{AM_AX,OP_NOP},'{AM_AX,OP_CMP},'{AM_AX,OP_DEC},'{AM_AX,OP_DCP},
'{AM_IM,OP_CPX},'{AM_IX,OP_SBC},'{AM_XX,OP_BAD},'{AM_IX,OP_ISB},'{AM_ZP,OP_CPX},'{AM_ZP,OP_SBC},
'{AM_ZP,OP_INC},'{AM_ZP,OP_ISB},'{AM_IP,OP_INX},'{AM_IM,OP_SBC},'{AM_IP,OP_NOP},'{AM_XX,OP_BAD},
'{AM_AB,OP_CPX},'{AM_AB,OP_SBC},'{AM_AB,OP_INC},'{AM_AB,OP_ISB},
'{AM_RE,OP_BEQ},'{AM_IY,OP_SBC},'{AM_XX,OP_BAD},'{AM_IY,OP_ISB},'{AM_ZX,OP_NOP},'{AM_ZX,OP_SBC},
'{AM_ZX,OP_INC},'{AM_ZX,OP_ISB},'{AM_IP,OP_SED},'{AM_AY,OP_SBC},'{AM_IP,OP_NOP},'{AM_AY,OP_ISB},
'{AM_AX,OP_NOP},'{AM_AX,OP_SBC},'{AM_AX,OP_INC},'{AM_AX,OP_ISB}
    };

    localparam dec_t TAB_CMOS [256] = '{
'{AM_XX,OP_BAD},'{AM_IX,OP_ORA},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZP,OP_TSB},'{AM_ZP,OP_ORA},
'{AM_ZP,OP_ASL},'{AM_ZP,OP_RMB},'{AM_IP,OP_PHP},'{AM_IM,OP_ORA},'{AM_IP,OP_ASL},'{AM_XX,OP_BAD},
'{AM_AB,OP_TSB},'{AM_AB,OP_ORA},'{AM_AB,OP_ASL},'{AM_BB,OP_BBR},
'{AM_RE,OP_BPL},'{AM_IY,OP_ORA},'{AM_IZ,OP_ORA},'{AM_XX,OP_BAD},'{AM_ZP,OP_TRB},'{AM_ZX,OP_ORA},
'{AM_ZX,OP_ASL},'{AM_ZP,OP_RMB},'{AM_IP,OP_CLC},'{AM_AY,OP_ORA},'{AM_IP,OP_INC},'{AM_XX,OP_BAD},
'{AM_AB,OP_TRB},'{AM_AX,OP_ORA},'{AM_AX,OP_ASL},'{AM_BB,OP_BBR},
'{AM_AB,OP_JSR},'{AM_IX,OP_AND},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZP,OP_BIT},'{AM_ZP,OP_AND},
'{AM_ZP,OP_ROL},'{AM_ZP,OP_RMB},'{AM_IP,OP_PLP},'{AM_IM,OP_AND},'{AM_IP,OP_ROL},'{AM_XX,OP_BAD},
'{AM_AB,OP_BIT},'{AM_AB,OP_AND},'{AM_AB,OP_ROL},'{AM_BB,OP_BBR},
'{AM_RE,OP_BMI},'{AM_IY,OP_AND},'{AM_IZ,OP_AND},'{AM_XX,OP_BAD},'{AM_ZX,OP_BIT},'{AM_ZX,OP_AND},
'{AM_ZX,OP_ROL},'{AM_ZP,OP_RMB},'{AM_IP,OP_SEC},'{AM_AY,OP_AND},'{AM_IP,OP_DEC},'{AM_XX,OP_BAD},
'{AM_AX,OP_NOP},'{AM_AX,OP_AND},'{AM_AX,OP_ROL},'{AM_BB,OP_BBR},
'{AM_IP,OP_RTI},'{AM_IX,OP_EOR},'{AM_I2,OP_HLE},'{AM_XX,OP_BAD},'{AM_ZP,OP_NOP},'{AM_ZP,OP_EOR},
'{AM_ZP,OP_LSR},'{AM_ZP,OP_RMB},'{AM_IP,OP_PHA},'{AM_IM,OP_EOR},'{AM_IP,OP_LSR},'{AM_XX,OP_BAD},
'{AM_AB,OP_JMP},'{AM_AB,OP_EOR},'{AM_AB,OP_LSR},'{AM_BB,OP_BBR},
'{AM_RE,OP_BVC},'{AM_IY,OP_EOR},'{AM_IZ,OP_EOR},'{AM_XX,OP_BAD},'{AM_ZX,OP_NOP},'{AM_ZX,OP_EOR},
'{AM_ZX,OP_LSR},'{AM_ZP,OP_RMB},'{AM_IP,OP_CLI},'{AM_AY,OP_EOR},'{AM_IP,OP_PHY},'{AM_XX,OP_BAD},
'{AM_AX,OP_NOP},'{AM_AX,OP_EOR},'{AM_AX,OP_LSR},'{AM_BB,OP_BBR},
'{AM_IP,OP_RTS},'{AM_IX,OP_ADC},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZP,OP_STZ},'{AM_ZP,OP_ADC},
'{AM_ZP,OP_ROR},'{AM_ZP,OP_RMB},'{AM_IP,OP_PLA},'{AM_IM,OP_ADC},'{AM_IP,OP_ROR},'{AM_XX,OP_BAD},
'{AM_IA,OP_JMP},'{AM_AB,OP_ADC},'{AM_AB,OP_ROR},'{AM_BB,OP_BBR},
'{AM_RE,OP_BVS},'{AM_IY,OP_ADC},'{AM_IZ,OP_ADC},'{AM_XX,OP_BAD},'{AM_ZX,OP_STZ},'{AM_ZX,OP_ADC},
'{AM_ZX,OP_ROR},'{AM_ZP,OP_RMB},'{AM_IP,OP_SEI},'{AM_AY,OP_ADC},'{AM_IP,OP_PLY},'{AM_XX,OP_BAD},
'{AM_IT,OP_JMP},'{AM_AX,OP_ADC},'{AM_AX,OP_ROR},'{AM_BB,OP_BBR},
'{AM_RE,OP_BRA},'{AM_IX,OP_STA},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZP,OP_STY},'{AM_ZP,OP_STA},
'{AM_ZP,OP_STX},'{AM_ZP,OP_SMB},'{AM_IP,OP_DEY},'{AM_IM,OP_STA},'{AM_IP,OP_TXA},'{AM_XX,OP_BAD},
'{AM_AB,OP_STY},'{AM_AB,OP_STA},'{AM_AB,OP_STX},'{AM_BB,OP_BBS},
'{AM_RE,OP_BCC},'{AM_IY,OP_STA},'{AM_IZ,OP_STA},'{AM_XX,OP_BAD},'{AM_ZX,OP_STY},'{AM_ZX,OP_STA},
'{AM_ZY,OP_STX},'{AM_ZP,OP_SMB},'{AM_IP,OP_TYA},'{AM_AY,OP_STA},'{AM_IP,OP_TXS},'{AM_XX,OP_BAD},
'{AM_AB,OP_STZ},'{AM_AX,OP_STA},'{AM_AX,OP_STZ},'{AM_BB,OP_BBS},
'{AM_IM,OP_LDY},'{AM_IX,OP_LDA},'{AM_IM,OP_LDX},'{AM_XX,OP_BAD},'{AM_ZP,OP_LDY},'{AM_ZP,OP_LDA},
'{AM_ZP,OP_LDX},'{AM_ZP,OP_SMB},'{AM_IP,OP_TAY},'{AM_IM,OP_LDA},'{AM_IP,OP_TAX},'{AM_XX,OP_BAD},
'{AM_AB,OP_LDY},'{AM_AB,OP_LDA},'{AM_AB,OP_LDX},'{AM_BB,OP_BBS},
'{AM_RE,OP_BCS},'{AM_IY,OP_LDA},'{AM_IZ,OP_LDA},'{AM_XX,OP_BAD},'{AM_ZX,OP_LDY},'{AM_ZX,OP_LDA},
'{AM_ZY,OP_LDX},'{AM_ZP,OP_SMB},'{AM_IP,OP_CLV},'{AM_AY,OP_LDA},'{AM_IP,OP_TSX},'{AM_XX,OP_BAD},
'{AM_AX,OP_LDY},'{AM_AX,OP_LDA},'{AM_AY,OP_LDX},'{AM_BB,OP_BBS},
'{AM_IM,OP_CPY},'{AM_IX,OP_CMP},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZP,OP_CPY},'{AM_ZP,OP_CMP},
'{AM_ZP,OP_DEC},'{AM_ZP,OP_SMB},'{AM_IP,OP_INY},'{AM_IM,OP_CMP},'{AM_IP,OP_DEX},'{AM_IP,OP_WAI},
'{AM_AB,OP_CPY},'{AM_AB,OP_CMP},'{AM_AB,OP_DEC},'{AM_BB,OP_BBS},
'{AM_RE,OP_BNE},'{AM_IY,OP_CMP},'{AM_IZ,OP_CMP},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZX,OP_CMP},
'{AM_ZX,OP_DEC},'{AM_ZP,OP_SMB},'{AM_IP,OP_CLD},'{AM_AY,OP_CMP},'{AM_IP,OP_PHX},'{AM_IP,OP_STP},
'{AM_AX,OP_NOP},'{AM_AX,OP_CMP},'{AM_AX,OP_DEC},'{AM_BB,OP_BBS},
'{AM_IM,OP_CPX},'{AM_IX,OP_SBC},'{AM_XX,OP_BAD},'{AM_XX,OP_BAD},'{AM_ZP,OP_CPX},'{AM_ZP,OP_SBC},
'{AM_ZP,OP_INC},'{AM_ZP,OP_SMB},'{AM_IP,OP_INX},'{AM_IM,OP_SBC},'{AM_IP,OP_NOP},'{AM_XX,OP_BAD},
'{AM_AB,OP_CPX},'{AM_AB,OP_SBC},'{AM_AB,OP_INC},'{AM_BB,OP_BBS},
'{AM_RE,OP_BEQ},'{AM_IY,OP_SBC},'{AM_IZ,OP_SBC},'{AM_XX,OP_BAD},'{AM_ZX,OP_NOP},'{AM_ZX,OP_SBC},
'{AM_ZX,OP_INC},'{AM_ZP,OP_SMB},'{AM_IP,OP_SED},'{AM_AY,OP_SBC},'{AM_IP,OP_PLX},'{AM_XX,OP_BAD},
'{AM_AX,OP_NOP},'{AM_AX,OP_SBC},'{AM_AX,OP_INC},'{AM_BB,OP_BBS}
    };

    localparam dec_t TAB_816 [256] = '{
'{AM_XX,OP_BAD},'{AM_IX,OP_ORA},'{AM_IM,OP_COP},'{AM_SR,OP_ORA},'{AM_ZP,OP_TSB},'{AM_ZP,OP_ORA},
'{AM_ZP,OP_ASL},'{AM_XD,OP_ORA},'{AM_IP,OP_PHP},'{AM_IM,OP_ORA},'{AM_IP,OP_ASL},'{AM_IP,OP_PHD},
'{AM_AB,OP_TSB},'{AM_AB,OP_ORA},'{AM_AB,OP_ASL},'{AM_LG,OP_ORA},
'{AM_RE,OP_BPL},'{AM_IY,OP_ORA},'{AM_IZ,OP_ORA},'{AM_SY,OP_ORA},'{AM_ZP,OP_TRB},'{AM_ZX,OP_ORA},
'{AM_ZX,OP_ASL},'{AM_XY,OP_ORA},'{AM_IP,OP_CLC},'{AM_AY,OP_ORA},'{AM_IP,OP_INC},'{AM_IP,OP_TCS},
'{AM_AB,OP_TRB},'{AM_AX,OP_ORA},'{AM_AX,OP_ASL},'{AM_LX,OP_ORA},
'{AM_AB,OP_JSR},'{AM_IX,OP_AND},'{AM_LG,OP_JSL},'{AM_SR,OP_AND},'{AM_ZP,OP_BIT},'{AM_ZP,OP_AND},
'{AM_ZP,OP_ROL},'{AM_XD,OP_AND},'{AM_IP,OP_PLP},'{AM_IM,OP_AND},'{AM_IP,OP_ROL},'{AM_IP,OP_PLD},
'{AM_AB,OP_BIT},'{AM_AB,OP_AND},'{AM_AB,OP_ROL},'{AM_LG,OP_AND},
'{AM_RE,OP_BMI},'{AM_IY,OP_AND},'{AM_IZ,OP_AND},'{AM_SY,OP_AND},'{AM_ZX,OP_BIT},'{AM_ZX,OP_AND},
'{AM_ZX,OP_ROL},'{AM_XY,OP_AND},'{AM_IP,OP_SEC},'{AM_AY,OP_AND},'{AM_IP,OP_DEC},'{AM_IP,OP_TSC},
'{AM_AX,OP_NOP},'{AM_AX,OP_AND},'{AM_AX,OP_ROL},'{AM_LX,OP_AND},
'{AM_IP,OP_RTI},'{AM_IX,OP_EOR},'{AM_I2,OP_HLE},'{AM_SR,OP_EOR},'{AM_MV,OP_MVP},'{AM_ZP,OP_EOR},
'{AM_ZP,OP_LSR},'{AM_XD,OP_EOR},'{AM_IP,OP_PHA},'{AM_IM,OP_EOR},'{AM_IP,OP_LSR},'{AM_IP,OP_PHK},
'{AM_AB,OP_JMP},'{AM_AB,OP_EOR},'{AM_AB,OP_LSR},'{AM_LG,OP_EOR},
'{AM_RE,OP_BVC},'{AM_IY,OP_EOR},'{AM_IZ,OP_EOR},'{AM_SY,OP_EOR},'{AM_MV,OP_MVN},'{AM_ZX,OP_EOR},
'{AM_ZX,OP_LSR},'{AM_XY,OP_EOR},'{AM_IP,OP_CLI},'{AM_AY,OP_EOR},'{AM_IP,OP_PHY},'{AM_IP,OP_TCD},
'{AM_AX,OP_NOP},'{AM_AX,OP_EOR},'{AM_AX,OP_LSR},'{AM_LX,OP_EOR},
'{AM_IP,OP_RTS},'{AM_IX,OP_ADC},'{AM_XX,OP_BAD},'{AM_SR,OP_ADC},'{AM_ZP,OP_STZ},'{AM_ZP,OP_ADC},
'{AM_ZP,OP_ROR},'{AM_XD,OP_ADC},'{AM_IP,OP_PLA},'{AM_IM,OP_ADC},'{AM_IP,OP_ROR},'{AM_IP,OP_RTL},
'{AM_IA,OP_JMP},'{AM_AB,OP_ADC},'{AM_AB,OP_ROR},'{AM_LG,OP_ADC},
'{AM_RE,OP_BVS},'{AM_IY,OP_ADC},'{AM_IZ,OP_ADC},'{AM_SY,OP_ADC},'{AM_ZX,OP_STZ},'{AM_ZX,OP_ADC},
'{AM_ZX,OP_ROR},'{AM_XY,OP_ADC},'{AM_IP,OP_SEI},'{AM_AY,OP_ADC},'{AM_IP,OP_PLY},'{AM_IP,OP_TDC},
'{AM_IT,OP_JMP},'{AM_AX,OP_ADC},'{AM_AX,OP_ROR},'{AM_LX,OP_ADC},
'{AM_RE,OP_BRA},'{AM_IX,OP_STA},'{AM_RL,OP_BRL},'{AM_SR,OP_STA},'{AM_ZP,OP_STY},'{AM_ZP,OP_STA},
'{AM_ZP,OP_STX},'{AM_XD,OP_STA},'{AM_IP,OP_DEY},'{AM_IM,OP_STA},'{AM_IP,OP_TXA},'{AM_IP,OP_PHB},
'{AM_AB,OP_STY},'{AM_AB,OP_STA},'{AM_AB,OP_STX},'{AM_LG,OP_STA},
'{AM_RE,OP_BCC},'{AM_IY,OP_STA},'{AM_IZ,OP_STA},'{AM_SY,OP_STA},'{AM_ZX,OP_STY},'{AM_ZX,OP_STA},
'{AM_ZY,OP_STX},'{AM_XY,OP_STA},'{AM_IP,OP_TYA},'{AM_AY,OP_STA},'{AM_IP,OP_TXS},'{AM_IP,OP_TXY},
'{AM_AB,OP_STZ},'{AM_AX,OP_STA},'{AM_AX,OP_STZ},'{AM_LX,OP_STA},
'{AM_IM,OP_LDY},'{AM_IX,OP_LDA},'{AM_IM,OP_LDX},'{AM_SR,OP_LDA},'{AM_ZP,OP_LDY},'{AM_ZP,OP_LDA},
'{AM_ZP,OP_LDX},'{AM_XD,OP_LDA},'{AM_IP,OP_TAY},'{AM_IM,OP_LDA},'{AM_IP,OP_TAX},'{AM_IP,OP_PLB},
'{AM_AB,OP_LDY},'{AM_AB,OP_LDA},'{AM_AB,OP_LDX},'{AM_LG,OP_LDA},
'{AM_RE,OP_BCS},'{AM_IY,OP_LDA},'{AM_IZ,OP_LDA},'{AM_SY,OP_LDA},'{AM_ZX,OP_LDY},'{AM_ZX,OP_LDA},
'{AM_ZY,OP_LDX},'{AM_XY,OP_LDA},'{AM_IP,OP_CLV},'{AM_AY,OP_LDA},'{AM_IP,OP_TSX},'{AM_IP,OP_TYX},
'{AM_AX,OP_LDY},'{AM_AX,OP_LDA},'{AM_AY,OP_LDX},'{AM_LX,OP_LDA},
'{AM_IM,OP_CPY},'{AM_IX,OP_CMP},'{AM_IM,OP_REP},'{AM_SR,OP_CMP},'{AM_ZP,OP_CPY},'{AM_ZP,OP_CMP},
'{AM_ZP,OP_DEC},'{AM_XD,OP_CMP},'{AM_IP,OP_INY},'{AM_IM,OP_CMP},'{AM_IP,OP_DEX},'{AM_IP,OP_WAI},
'{AM_AB,OP_CPY},'{AM_AB,OP_CMP},'{AM_AB,OP_DEC},'{AM_LG,OP_CMP},
'{AM_RE,OP_BNE},'{AM_IY,OP_CMP},'{AM_IZ,OP_CMP},'{AM_SY,OP_CMP},'{AM_IZ,OP_PEI},'{AM_ZX,OP_CMP},
'{AM_ZX,OP_DEC},'{AM_XY,OP_CMP},'{AM_IP,OP_CLD},'{AM_AY,OP_CMP},'{AM_IP,OP_PHX},'{AM_IP,OP_STP},
'{AM_IL,OP_JML},'{AM_AX,OP_CMP},'{AM_AX,OP_DEC},'{AM_LX,OP_CMP},
'{AM_IM,OP_CPX},'{AM_IX,OP_SBC},'{AM_IM,OP_SEP},'{AM_SR,OP_SBC},'{AM_ZP,OP_CPX},'{AM_ZP,OP_SBC},
'{AM_ZP,OP_INC},'{AM_XD,OP_SBC},'{AM_IP,OP_INX},'{AM_IM,OP_SBC},'{AM_IP,OP_NOP},'{AM_IP,OP_XBA},
'{AM_AB,OP_CPX},'{AM_AB,OP_SBC},'{AM_AB,OP_INC},'{AM_LG,OP_SBC},
'{AM_RE,OP_BEQ},'{AM_IY,OP_SBC},'{AM_IZ,OP_SBC},'{AM_SY,OP_SBC},'{AM_I2,OP_PEA},'{AM_ZX,OP_SBC},
'{AM_ZX,OP_INC},'{AM_XY,OP_SBC},'{AM_IP,OP_SED},'{AM_AY,OP_SBC},'{AM_IP,OP_PLX},'{AM_IP,OP_XCE},
'{AM_IT,OP_JSR},'{AM_AX,OP_SBC},'{AM_AX,OP_INC},'{AM_LX,OP_SBC}
    };

endpackage
`default_nettype wire

### sv/m6502_family_insn_predecoder.sv
// A beat accepted with start passes the lookup, sums and output registers and is marked by done.
// Throughput: one instruction per cycle; the three stages are table lookup,
// address adders and result select, and busy is never raised.
// The receiver cannot stall, so done strobes exactly once per accepted beat.
// Reset clears the stage valid bits and sets variant_reg to NMOS 6502.
`default_nettype none
module m6502_family_insn_predecoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    input  wire logic [15:0] pc,
    input  wire logic [7:0]  opcode_byte,
    input  wire logic [7:0]  operand_lo,
    input  wire logic [7:0]  operand_mid,
    input  wire logic [7:0]  operand_hi,
    input  wire logic [15:0] index_x,
    input  wire logic [15:0] index_y,
    input  wire logic [15:0] stack_ptr,
    output logic             done,
    output logic [4:0]       addr_mode,
    output logic [6:0]       op_id,
    output logic [2:0]       insn_length,
    output logic [15:0]      next_pc,
    output logic [23:0]      operand_base,
    output logic [23:0]      eff_addr,
    output logic [23:0]      pointer_addr,
    output logic [15:0]      branch_target,
    output logic [1:0]       addr_class,
    output logic [1:0]       operand_width,
    output logic             is_store
);

    logic [1:0]          variant_reg;
    logic                look_valid;
    m6502_pd_pkg::look_t look;
    logic                sums_valid;
    m6502_pd_pkg::sums_t sums;

    logic        done_reg;
    logic [4:0]  mode_reg;
    logic [6:0]  op_reg;
    logic [2:0]  len_reg;
    logic [15:0] npc_reg;
    logic [23:0] base_reg, base_next;
    logic [23:0] ea_reg, ea_next;
    logic [23:0] ptr_reg, ptr_next;
    logic [15:0] tgt_reg, tgt_next;
    logic [1:0]  cls_reg, cls_next;
    logic [1:0]  wid_reg, wid_next;
    logic        store_reg, store_next;
    logic [23:0] w16z;
    logic [23:0] loz;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= m6502_pd_pkg::CPU_NMOS;
        end
        else if (cfg_wr_en)
        begin
            variant_reg <= cfg_wr_data;
        end
    end

    m6502_pd_lookup u_lookup (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .variant     (variant_reg),
        .pc          (pc),
        .opcode_byte (opcode_byte),
        .operand_lo  (operand_lo),
        .operand_mid (operand_mid),
        .operand_hi  (operand_hi),
        .index_x     (index_x),
        .index_y     (index_y),
        .stack_ptr   (stack_ptr),
        .look_valid  (look_valid),
        .look        (look)
    );

    m6502_pd_sums u_sums (
        .clk        (clk),
        .rst_n      (rst_n),
        .look_valid (look_valid),
        .look       (look),
        .sums_valid (sums_valid),
        .sums       (sums)
    );

    always_comb
    begin
        w16z       = {8'd0, sums.w24[15:0]};
        loz        = {16'd0, sums.w24[7:0]};
        base_next  = 24'd0;
        ea_next    = 24'd0;
        ptr_next   = 24'd0;
        tgt_next   = 16'd0;
        cls_next   = m6502_pd_pkg::CLS_NONE;
        wid_next   = m6502_pd_pkg::WID_BYTE;
        store_next = (sums.op == m6502_pd_pkg::OP_STA) || (sums.op == m6502_pd_pkg::OP_STX)
                  || (sums.op == m6502_pd_pkg::OP_STY) || (sums.op == m6502_pd_pkg::OP_STZ);
        unique case (sums.mode) inside
            m6502_pd_pkg::AM_RE:
            begin
                tgt_next  = sums.rel_tgt;
                base_next = {8'd0, sums.rel_tgt};
                cls_next  = m6502_pd_pkg::CLS_BRANCH;
                wid_next  = m6502_pd_pkg::WID_WORD;
            end
            m6502_pd_pkg::AM_RL:
            begin
                tgt_next  = sums.rel16_tgt;
                base_next = {8'd0, sums.rel16_tgt};
                cls_next  = m6502_pd_pkg::CLS_BRANCH;
                wid_next  = m6502_pd_pkg::WID_WORD;
            end
            m6502_pd_pkg::AM_IM:
            begin
                base_next = loz;
            end
            m6502_pd_pkg::AM_I2, m6502_pd_pkg::AM_MV:
            begin
                base_next = w16z;
                wid_next  = m6502_pd_pkg::WID_WORD;
            end
            m6502_pd_pkg::AM_ZP:
            begin
                base_next = loz;
                ea_next   = loz;
                cls_next  = m6502_pd_pkg::CLS_DIRECT;
            end
            m6502_pd_pkg::AM_ZX:
            begin
                base_next = loz;
                ea_next   = {16'd0, sums.zx};
                cls_next  = m6502_pd_pkg::CLS_DIRECT;
            end
            m6502_pd_pkg::AM_ZY:
            begin
                base_next = loz;
                ea_next   = {16'd0, sums.zy};
                cls_next  = m6502_pd_pkg::CLS_DIRECT;
            end
            m6502_pd_pkg::AM_AB:
            begin
                base_next = w16z;
                ea_next   = w16z;
                cls_next  = m6502_pd_pkg::CLS_DIRECT;
                wid_next  = m6502_pd_pkg::WID_WORD;
            end
            m6502_pd_pkg::AM_AX:
            begin
                base_next = w16z;
                ea_next   = sums.ax;
                cls_next  = m6502_pd_pkg::CLS_DIRECT;
                wid_next  = m6502_pd_pkg::WID_WORD;
            end
            m6502_pd_pkg::AM_AY:
            begin
                base_next = w16z;
                ea_next   = sums.ay;
                cls_next  = m6502_pd_pkg::CLS_DIRECT;
                wid_next  = m6502_pd_pkg::WID_WORD;
            end
            m6502_pd_pkg::AM_IA, m6502_pd_pkg::AM_IL:
            begin
                base_next = w16z;
                ptr_next  = w16z;
                cls_next  = m6502_pd_pkg::CLS_PTR;
                wid_next  = m6502_pd_pkg::WID_WORD;
            end
            m6502_pd_pkg::AM_IX:
            begin
                base_next = loz;
                ptr_next  = {16'd0, sums.zx};
                cls_next  = m6502_pd_pkg::CLS_PTR;
            end
            m6502_pd_pkg::AM_IY, m6502_pd_pkg::AM_IZ, m6502_pd_pkg::AM_XD, m6502_pd_pkg::AM_XY:
            begin
                base_next = loz;
                ptr_next  = loz;
                cls_next  = m6502_pd_pkg::CLS_PTR;
            end
            m6502_pd_pkg::AM_IT:
            begin
                base_next = w16z;
                ptr_next  = sums.ax;
                cls_next  = m6502_pd_pkg::CLS_PTR;
                wid_next  = m6502_pd_pkg::WID_WORD;
            end
            m6502_pd_pkg::AM_BB:
            begin
                // The bit branch offset is the second operand byte.
                base_next = loz;
                tgt_next  = sums.bb_tgt;
                cls_next  = m6502_pd_pkg::CLS_BRANCH;
            end
            m6502_pd_pkg::AM_LG:
            begin
                base_next = sums.w24;
                ea_next   = sums.w24;
                cls_next  = m6502_pd_pkg::CLS_DIRECT;
                wid_next  = m6502_pd_pkg::WID_LONG;
            end
            m6502_pd_pkg::AM_LX:
            begin
                base_next = sums.w24;
                ea_next   = sums.lx;
                cls_next  = m6502_pd_pkg::CLS_DIRECT;
                wid_next  = m6502_pd_pkg::WID_LONG;
            end
            m6502_pd_pkg::AM_SR:
            begin
                base_next = loz;
                ea_next   = sums.sr;
                cls_next  = m6502_pd_pkg::CLS_DIRECT;
            end
            m6502_pd_pkg::AM_SY:
            begin
                base_next = loz;
                ptr_next  = sums.sr;
                cls_next  = m6502_pd_pkg::CLS_PTR;
            end
            default:
            begin
                base_next = 24'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sums_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sums_valid)
        begin
            mode_reg  <= sums.mode;
            op_reg    <= sums.op;
            len_reg   <= sums.len;
            npc_reg   <= sums.next_pc;
            base_reg  <= base_next;
            ea_reg    <= ea_next;
            ptr_reg   <= ptr_next;
            tgt_reg   <= tgt_next;
            cls_reg   <= cls_next;
            wid_reg   <= wid_next;
            store_reg <= store_next;
        end
    end

    assign done          = done_reg;
    assign addr_mode     = mode_reg;
    assign op_id         = op_reg;
    assign insn_length   = len_reg;
    assign next_pc       = npc_reg;
    assign operand_base  = base_reg;
    assign eff_addr      = ea_reg;
    assign pointer_addr  = ptr_reg;
    assign branch_target = tgt_reg;
    assign addr_class    = cls_reg;
    assign operand_width = wid_reg;
    assign is_store      = store_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("done without a matching start");

    a_no_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (addr_class == m6502_pd_pkg::CLS_NONE)
        |-> (eff_addr == 24'd0) && (pointer_addr == 24'd0) && (branch_target == 16'd0))
        else $error("address output set for a mode without an address");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (insn_length != 3'd0) && (insn_length <= 3'd4))
        else $error("instruction length out of range");

    a_next_pc: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> next_pc == $past(pc, 3) + {13'd0, insn_length})
        else $error("next_pc does not match pc plus length");

endmodule
`default_nettype wire

### sv/m6502_pd_lookup.sv
`default_nettype none
module m6502_pd_lookup (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [1:0]           variant,
    input  wire logic [15:0]          pc,
    input  wire logic [7:0]           opcode_byte,
    input  wire logic [7:0]           operand_lo,
    input  wire logic [7:0]           operand_mid,
    input  wire logic [7:0]           operand_hi,
    input  wire logic [15:0]          index_x,
    input  wire logic [15:0]          index_y,
    input  wire logic [15:0]          stack_ptr,
    output logic                      look_valid,
    output m6502_pd_pkg::look_t       look
);

    logic                valid_reg;
    m6502_pd_pkg::look_t look_reg;
    m6502_pd_pkg::look_t look_next;
    m6502_pd_pkg::dec_t  entry;

    always_comb
    begin
        unique case (variant)
            m6502_pd_pkg::CPU_NMOS: entry = m6502_pd_pkg::TAB_NMOS[opcode_byte];
            m6502_pd_pkg::CPU_CMOS: entry = m6502_pd_pkg::TAB_CMOS[opcode_byte];
            default:                entry = m6502_pd_pkg::TAB_816[opcode_byte];
        endcase
        look_next.mode = entry.mode;
        look_next.op   = entry.op;
        look_next.pc   = pc;
        look_next.lo   = operand_lo;
        look_next.mid  = operand_mid;
        look_next.hi   = operand_hi;
        look_next.x    = index_x;
        look_next.y    = index_y;
        look_next.s    = stack_ptr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            look_reg <= look_next;
        end
    end

    assign look_valid = valid_reg;
    assign look       = look_reg;

endmodule
`default_nettype wire

### sv/m6502_pd_sums.sv
`default_nettype none
module m6502_pd_sums (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 look_valid,
    input  wire m6502_pd_pkg::look_t  look,
    output logic                      sums_valid,
    output m6502_pd_pkg::sums_t       sums
);

    logic                valid_reg;
    m6502_pd_pkg::sums_t sums_reg;
    m6502_pd_pkg::sums_t sums_next;
    logic [15:0]         w16;
    logic [2:0]          len;

    always_comb
    begin
        w16 = {look.mid, look.lo};
        len = m6502_pd_pkg::mode_len(look.mode);
        sums_next.mode      = look.mode;
        sums_next.op        = look.op;
        sums_next.len       = len;
        sums_next.next_pc   = look.pc + {13'd0, len};
        sums_next.w24       = {look.hi, w16};
        // Branch offsets are sign-extended bytes or words; targets wrap at 16 bits.
        sums_next.rel_tgt   = look.pc + 16'd2 + {{8{look.lo[7]}}, look.lo};
        sums_next.rel16_tgt = look.pc + 16'd3 + w16;
        sums_next.bb_tgt    = look.pc + 16'd3 + {{8{look.mid[7]}}, look.mid};
        sums_next.zx        = look.lo + look.x[7:0];
        sums_next.zy        = look.lo + look.y[7:0];
        sums_next.ax        = {8'd0, w16} + {8'd0, look.x};
        sums_next.ay        = {8'd0, w16} + {8'd0, look.y};
        sums_next.lx        = {look.hi, w16} + {8'd0, look.x};
        sums_next.sr        = {16'd0, look.lo} + {8'd0, look.s};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= look_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (look_valid)
        begin
            sums_reg <= sums_next;
        end
    end

    assign sums_valid = valid_reg;
    assign sums       = sums_reg;

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 5;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  opc;
        logic [7:0]  lo;
        logic [7:0]  mid;
        logic [7:0]  hi;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] s;
    } insn_t;

    typedef struct packed {
        logic [4:0]  mode;
        logic [6:0]  op;
        logic [2:0]  len;
        logic [15:0] next_pc;
        logic [23:0] base;
        logic [23:0] ea;
        logic [23:0] ptr;
        logic [15:0] tgt;
        logic [1:0]  cls;
        logic [1:0]  wid;
        logic        store;
    } decode_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic [15:0] pc;
    logic [7:0]  opcode_byte;
    logic [7:0]  operand_lo;
    logic [7:0]  operand_mid;
    logic [7:0]  operand_hi;
    logic [15:0] index_x;
    logic [15:0] index_y;
    logic [15:0] stack_ptr;
    logic        done;
    logic [4:0]  addr_mode;
    logic [6:0]  op_id;
    logic [2:0]  insn_length;
    logic [15:0] next_pc;
    logic [23:0] operand_base;
    logic [23:0] eff_addr;
    logic [23:0] pointer_addr;
    logic [15:0] branch_target;
    logic [1:0]  addr_class;
    logic [1:0]  operand_width;
    logic        is_store;

    decode_t     pending_decodes[$];
    logic [1:0]  variant_shadow;
    int          mismatches;
    int          idle_cycles;

    m6502_family_insn_predecoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .pc            (pc),
        .opcode_byte   (opcode_byte),
        .operand_lo    (operand_lo),
        .operand_mid   (operand_mid),
        .operand_hi    (operand_hi),
        .index_x       (index_x),
        .index_y       (index_y),
        .stack_ptr     (stack_ptr),
        .done          (done),
        .addr_mode     (addr_mode),
        .op_id         (op_id),
        .insn_length   (insn_length),
        .next_pc       (next_pc),
        .operand_base  (operand_base),
        .eff_addr      (eff_addr),
        .pointer_addr  (pointer_addr),
        .branch_target (branch_target),
        .addr_class    (addr_class),
        .operand_width (operand_width),
        .is_store      (is_store)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic decode_t decode_insn(input insn_t i, input logic [1:0] variant);
        decode_t             d;
        m6502_pd_pkg::dec_t  ent;
        logic [15:0]         w16;
        logic [23:0]         w24;
        logic [23:0]         w16_ext;
        begin
            if (variant == m6502_pd_pkg::CPU_NMOS)
                ent = m6502_pd_pkg::TAB_NMOS[i.opc];
            else if (variant == m6502_pd_pkg::CPU_CMOS)
                ent = m6502_pd_pkg::TAB_CMOS[i.opc];
            else
                ent = m6502_pd_pkg::TAB_816[i.opc];
            w16 = {i.mid, i.lo};
            w24 = {i.hi, i.mid, i.lo};
            w16_ext = {8'h00, w16};
            d = '0;
            d.mode = ent.mode;
            d.op = ent.op;
            case (ent.mode)
                m6502_pd_pkg::AM_XX, m6502_pd_pkg::AM_IP: d.len = 3'd1;
                m6502_pd_pkg::AM_LG, m6502_pd_pkg::AM_LX: d.len = 3'd4;
                m6502_pd_pkg::AM_RL, m6502_pd_pkg::AM_I2, m6502_pd_pkg::AM_AB,
                m6502_pd_pkg::AM_AX, m6502_pd_pkg::AM_AY, m6502_pd_pkg::AM_IA,
                m6502_pd_pkg::AM_IL, m6502_pd_pkg::AM_IT, m6502_pd_pkg::AM_BB,
                m6502_pd_pkg::AM_MV:
                    d.len = 3'd3;
                default: d.len = 3'd2;
            endcase
            d.next_pc = i.pc + 16'(d.len);
            case (ent.mode)
                m6502_pd_pkg::AM_RE: begin
                    d.tgt = i.pc + 16'd2 + {{8{i.lo[7]}}, i.lo};
                    d.base = {8'h00, d.tgt};
                    d.cls = m6502_pd_pkg::CLS_BRANCH;
                    d.wid = m6502_pd_pkg::WID_WORD;
                end
                m6502_pd_pkg::AM_RL: begin
                    d.tgt = i.pc + 16'd3 + w16;
                    d.base = {8'h00, d.tgt};
                    d.cls = m6502_pd_pkg::CLS_BRANCH;
                    d.wid = m6502_pd_pkg::WID_WORD;
                end
                m6502_pd_pkg::AM_IM: d.base = {16'h0, i.lo};
                m6502_pd_pkg::AM_I2, m6502_pd_pkg::AM_MV: begin
                    d.base = w16_ext;
                    d.wid = m6502_pd_pkg::WID_WORD;
                end
                m6502_pd_pkg::AM_ZP: begin
                    d.base = {16'h0, i.lo};
                    d.ea = {16'h0, i.lo};
                    d.cls = m6502_pd_pkg::CLS_DIRECT;
                end
                m6502_pd_pkg::AM_ZX: begin
                    d.base = {16'h0, i.lo};
                    d.ea = {16'h0, 8'(i.lo + i.x[7:0])};
                    d.cls = m6502_pd_pkg::CLS_DIRECT;
                end
                m6502_pd_pkg::AM_ZY: begin
                    d.base = {16'h0, i.lo};
                    d.ea = {16'h0, 8'(i.lo + i.y[7:0])};
                    d.cls = m6502_pd_pkg::CLS_DIRECT;
                end
                m6502_pd_pkg::AM_AB: begin
                    d.base = w16_ext;
                    d.ea = w16_ext;
                    d.cls = m6502_pd_pkg::CLS_DIRECT;
                    d.wid = m6502_pd_pkg::WID_WORD;
                end
                m6502_pd_pkg::AM_AX: begin
                    d.base = w16_ext;
                    d.ea = w16_ext + {8'h00, i.x};
                    d.cls = m6502_pd_pkg::CLS_DIRECT;
                    d.wid = m6502_pd_pkg::WID_WORD;
                end
                m6502_pd_pkg::AM_AY: begin
                    d.base = w16_ext;
                    d.ea = w16_ext + {8'h00, i.y};
                    d.cls = m6502_pd_pkg::CLS_DIRECT;
                    d.wid = m6502_pd_pkg::WID_WORD;
                end
                m6502_pd_pkg::AM_IA, m6502_pd_pkg::AM_IL: begin
                    d.base = w16_ext;
                    d.ptr = w16_ext;
                    d.cls = m6502_pd_pkg::CLS_PTR;
                    d.wid = m6502_pd_pkg::WID_WORD;
                end
                m6502_pd_pkg::AM_IX: begin
                    d.base = {16'h0, i.lo};
                    d.ptr = {16'h0, 8'(i.lo + i.x[7:0])};
                    d.cls = m6502_pd_pkg::CLS_PTR;
                end
                m6502_pd_pkg::AM_IY, m6502_pd_pkg::AM_IZ, m6502_pd_pkg::AM_XD,
                m6502_pd_pkg::AM_XY: begin
                    d.base = {16'h0, i.lo};
                    d.ptr = {16'h0, i.lo};
                    d.cls = m6502_pd_pkg::CLS_PTR;
                end
                m6502_pd_pkg::AM_IT: begin
                    d.base = w16_ext;
                    d.ptr = w16_ext + {8'h00, i.x};
                    d.cls = m6502_pd_pkg::CLS_PTR;
                    d.wid = m6502_pd_pkg::WID_WORD;
                end
                m6502_pd_pkg::AM_BB: begin
                    // The bit branch offset sits in the second operand byte.
                    d.base = {16'h0, i.lo};
                    d.tgt = i.pc + 16'd3 + {{8{i.mid[7]}}, i.mid};
                    d.cls = m6502_pd_pkg::CLS_BRANCH;
                end
                m6502_pd_pkg::AM_LG: begin
                    d.base = w24;
                    d.ea = w24;
                    d.cls = m6502_pd_pkg::CLS_DIRECT;
                    d.wid = m6502_pd_pkg::WID_LONG;
                end
                m6502_pd_pkg::AM_LX: begin
                    d.base = w24;
                    d.ea = w24 + {8'h00, i.x};
                    d.cls = m6502_pd_pkg::CLS_DIRECT;
                    d.wid = m6502_pd_pkg::WID_LONG;
                end
                m6502_pd_pkg::AM_SR: begin
                    d.base = {16'h0, i.lo};
                    d.ea = {16'h0, i.lo} + {8'h00, i.s};
                    d.cls = m6502_pd_pkg::CLS_DIRECT;
                end
                m6502_pd_pkg::AM_SY: begin
                    d.base = {16'h0, i.lo};
                    d.ptr = {16'h0, i.lo} + {8'h00, i.s};
                    d.cls = m6502_pd_pkg::CLS_PTR;
                end
                default: ;
            endcase
            d.store = (ent.op == m6502_pd_pkg::OP_STA) || (ent.op == m6502_pd_pkg::OP_STX) ||
                      (ent.op == m6502_pd_pkg::OP_STY) || (ent.op == m6502_pd_pkg::OP_STZ);
            return d;
        end
    endfunction

    task automatic compare_field(input string name, input logic [23:0] exp_v,
                                 input logic [23:0] act_v);
        begin
            if (exp_v !== act_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
            end
        end
    endtask

    always @(posedge clk) begin
        decode_t d;
        if (rst_n && done) begin
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result beat with no instruction pending");
            end else begin
                d = pending_decodes.pop_front();
                compare_field("addr_mode", 24'(d.mode), 24'(addr_mode));
                compare_field("op_id", 24'(d.op), 24'(op_id));
                compare_field("insn_length", 24'(d.len), 24'(insn_length));
                compare_field("next_pc", 24'(d.next_pc), 24'(next_pc));
                compare_field("operand_base", d.base, operand_base);
                compare_field("eff_addr", d.ea, eff_addr);
                compare_field("pointer_addr", d.ptr, pointer_addr);
                compare_field("branch_target", 24'(d.tgt), 24'(branch_target));
                compare_field("addr_class", 24'(d.cls), 24'(addr_class));
                compare_field("operand_width", 24'(d.wid), 24'(operand_width));
                compare_field("is_store", 24'(d.store), 24'(is_store));
            end
        end
    end

    // Counts cycles in which no beat moves on either side.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            else
                return $urandom_range(8, 40);
        end
    endfunction

    task automatic send_insn(input insn_t i, input bit allow_gaps);
        int gap;
        begin
            start <= 1'b1;
            pc <= i.pc;
            opcode_byte <= i.opc;
            operand_lo <= i.lo;
            operand_mid <= i.mid;
            operand_hi <= i.hi;
            index_x <= i.x;
            index_y <= i.y;
            stack_ptr <= i.s;
            do @(posedge clk); while (busy);
            pending_decodes.push_back(decode_insn(i, variant_shadow));
            gap = allow_gaps ? pick_gap() : 0;
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_decodes.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic set_variant(input logic [1:0] v);
        begin
            wait_drained();
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= v;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            variant_shadow = v;
            @(posedge clk);
        end
    endtask

    function automatic insn_t make_insn(input logic [15:0] a, input logic [7:0] o,
                                        input logic [7:0] l, input logic [7:0] m,
                                        input logic [7:0] h, input logic [15:0] x,
                                        input logic [15:0] y, input logic [15:0] s);
        insn_t i;
        begin
            i = '{pc: a, opc: o, lo: l, mid: m, hi: h, x: x, y: y, s: s};
            return i;
        end
    endfunction

    function automatic logic [15:0] corner16();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                return 16'h0000;
            else if (r == 1)
                return 16'hffff;
            else if (r == 2)
                return 16'h00ff;
            else
                return 16'($urandom);
        end
    endfunction

    // NMOS table straight after reset: extremes, wraps and the undefined opcode.
    task automatic test_nmos_directed();
        begin
            send_insn(make_insn(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0), 0);
            send_insn(make_insn(16'hffff, 8'h02, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff,
                                16'hffff), 0);
            send_insn(make_insn(16'hfffe, 8'h4c, 8'hff, 8'hff, 8'hff, 16'h0, 16'h0, 16'h0), 1);
            send_insn(make_insn(16'h1234, 8'hb5, 8'hf0, 8'h00, 8'h00, 16'h0120, 16'h0, 16'h0), 1);
            send_insn(make_insn(16'h1234, 8'hb6, 8'h80, 8'h00, 8'h00, 16'h0, 16'hff80, 16'h0), 0);
            send_insn(make_insn(16'hfffe, 8'hd0, 8'h7f, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0), 0);
            send_insn(make_insn(16'h0001, 8'h10, 8'h80, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0), 1);
            send_insn(make_insn(16'h2000, 8'hbd, 8'hff, 8'hff, 8'h00, 16'hffff, 16'h0, 16'h0), 0);
            send_insn(make_insn(16'h2000, 8'ha1, 8'hff, 8'h00, 8'h00, 16'h0001, 16'h0, 16'h0), 0);
            send_insn(make_insn(16'h2000, 8'h6c, 8'hff, 8'h12, 8'h00, 16'h0, 16'h0, 16'h0), 1);
            send_insn(make_insn(16'h2000, 8'h8d, 8'h00, 8'h40, 8'h00, 16'h0, 16'h0, 16'h0), 0);
        end
    endtask

    // 65C02: bit branches take their offset from the second byte, plus (abs,X) and STZ.
    task automatic test_cmos_directed();
        begin
            set_variant(m6502_pd_pkg::CPU_CMOS);
            send_insn(make_insn(16'hfffd, 8'h0f, 8'h12, 8'h80, 8'h55, 16'h0, 16'h0, 16'h0), 0);
            send_insn(make_insn(16'h0100, 8'hff, 8'hff, 8'h7f, 8'h00, 16'h0, 16'h0, 16'h0), 0);
            send_insn(make_insn(16'h0100, 8'h7c, 8'hff, 8'hff, 8'h00, 16'hffff, 16'h0, 16'h0), 1);
            send_insn(make_insn(16'h0100, 8'h9e, 8'h34, 8'h12, 8'h00, 16'h0010, 16'h0, 16'h0), 0);
            send_insn(make_insn(16'h0100, 8'h03, 8'h34, 8'h12, 8'h00, 16'h0, 16'h0, 16'h0), 0);
        end
    endtask

    // 65C816: long modes, stack relative, long indirect and block move.
    task automatic test_816_directed();
        begin
            set_variant(m6502_pd_pkg::CPU_816);
            send_insn(make_insn(16'h8000, 8'h82, 8'h00, 8'h80, 8'h00, 16'h0, 16'h0, 16'h0), 0);
            send_insn(make_insn(16'h8000, 8'h9f, 8'hff, 8'hff, 8'hff, 16'hffff, 16'h0, 16'h0), 0);
            send_insn(make_insn(16'h8000, 8'h23, 8'hff, 8'h00, 8'h00, 16'h0, 16'h0, 16'hffff), 1);
            send_insn(make_insn(16'h8000, 8'h93, 8'h80, 8'h00, 8'h00, 16'h0, 16'h1234,
                                16'hff00), 0);
            send_insn(make_insn(16'h8000, 8'hb7, 8'h44, 8'h00, 8'h00, 16'h0, 16'hffff, 16'h0), 0);
            send_insn(make_insn(16'h8000, 8'h54, 8'h01, 8'h02, 8'h03, 16'h0, 16'h0, 16'h0), 1);
            send_insn(make_insn(16'h8000, 8'hdc, 8'hfe, 8'hff, 8'h00, 16'h0, 16'h0, 16'h0), 0);
        end
    endtask

    // The unused variant code falls back to the 65C816 table.
    task automatic test_unused_variant();
        begin
            set_variant(2'd3);
            send_insn(make_insn(16'h4000, 8'h42, 8'hff, 8'hff, 8'h00, 16'h0, 16'h0, 16'h0), 0);
            send_insn(make_insn(16'h4000, 8'hfc, 8'h00, 8'h90, 8'h00, 16'h8000, 16'h0, 16'h0), 0);
        end
    endtask

    task automatic test_random_stream(input int count);
        insn_t i;
        int    n;
        begin
            for (n = 0; n < count; n++) begin
                if (n % 175 == 0)
                    set_variant(2'($urandom_range(0, 3)));
                i.pc = corner16();
                i.opc = 8'($urandom);
                i.lo = 8'($urandom);
                i.mid = 8'($urandom);
                i.hi = 8'($urandom);
                i.x = corner16();
                i.y = corner16();
                i.s = corner16();
                // Long runs with no gaps alternate with gappy stretches.
                send_insn(i, (n / 60) % 3 != 0);
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 2'd0;
        pc = '0;
        opcode_byte = '0;
        operand_lo = '0;
        operand_mid = '0;
        operand_hi = '0;
        index_x = '0;
        index_y = '0;
        stack_ptr = '0;
        mismatches = 0;
        idle_cycles = 0;
        variant_shadow = m6502_pd_pkg::CPU_NMOS;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_nmos_directed();
        test_cmos_directed();
        test_816_directed();
        test_unused_variant();
        test_random_stream(1400);
        set_variant(m6502_pd_pkg::CPU_NMOS);
        wait_drained();

        if (mismatches == 0 && pending_decodes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
sv/m6502_pd_pkg.sv
sv/m6502_pd_lookup.sv
sv/m6502_pd_sums.sv
sv/m6502_family_insn_predecoder.sv
dv/tb_top.sv
